FILE: hw/rtl/v3a_pkg.sv
`timescale 1ns / 1ps
// Shared types, opcodes and saturation helpers for the vector ALU.
// No dependencies.
package v3a_pkg;

    localparam int ROOT_W = 32;
    localparam int QUO_W  = 32;
    localparam int COSD_W = 64;
    localparam int NRMD_W = 32;

    typedef logic signed [31:0] q16_t;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_DOT   = 4'd2,
        OP_CROSS = 4'd3,
        OP_COS   = 4'd4,
        OP_NORM  = 4'd5,
        OP_MAG   = 4'd6,
        OP_ADDS  = 4'd7,
        OP_SUBS  = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        q16_t val;
        logic sat;
    } sat_t;

    typedef struct packed {
        op_t  op;
        q16_t ax;
        q16_t ay;
        q16_t az;
        q16_t bx;
        q16_t by_comp;
        q16_t bz;
        q16_t scalar_in;
    } item_t;

    typedef struct packed {
        q16_t    rx;
        q16_t    ry;
        q16_t    rz;
        q16_t    sc;
        status_t status;
    } res_t;

    typedef struct packed {
        op_t              op;
        res_t             early;
        logic             dot_neg;
        logic [63:0]      dot_mag;
        logic [2:0]       a_neg;
        logic [2:0][31:0] a_abs;
    } mid_t;

    typedef struct packed {
        mid_t        mid;
        logic [63:0] ssq_a;
        logic [63:0] ssq_b;
    } front_t;

    typedef struct packed {
        op_t         op;
        res_t        early;
        logic        dot_neg;
        logic [2:0]  a_neg;
        logic [31:0] ma;
        logic        zero_a;
        logic        zero_b;
        logic        big;
    } tail_t;

    function automatic sat_t sat_q(input logic signed [49:0] v);
        sat_t r;
        if (v > 50'sd2147483647) begin
            r.val = 32'sh7FFF_FFFF;
            r.sat = 1'b1;
        end else if (v < -50'sd2147483648) begin
            r.val = 32'sh8000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // sign applied to a magnitude, then clamped
    function automatic sat_t sign_sat(input logic neg, input logic [31:0] m);
        sat_t r;
        if (!neg) begin
            if (m > 32'h7FFF_FFFF) begin
                r.val = 32'sh7FFF_FFFF;
                r.sat = 1'b1;
            end else begin
                r.val = m;
                r.sat = 1'b0;
            end
        end else begin
            if (m > 32'h8000_0000) begin
                r.val = 32'sh8000_0000;
                r.sat = 1'b1;
            end else begin
                r.val = ~m + 32'd1;
                r.sat = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/v3a_front.sv
`timescale 1ns / 1ps
// Front end: products, sums of squares, dot and cross, component sums (3 stages).
// Depends on v3a_pkg.
module v3a_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  v3a_pkg::item_t  in_item,
    output logic            out_valid,
    output v3a_pkg::front_t out_data
);
    import v3a_pkg::*;

    q16_t av [3];
    q16_t bv [3];
    q16_t opnd;
    logic sub_sel;
    logic scl_sel;

    // stage 1
    logic                    v1_reg;
    op_t                     op1_reg;
    logic signed [63:0]      pd_reg [3];
    logic signed [63:0]      pd_next [3];
    logic signed [63:0]      pc_reg [6];
    logic signed [63:0]      pc_next [6];
    logic signed [63:0]      qa_reg [3];
    logic signed [63:0]      qa_next [3];
    logic signed [63:0]      qb_reg [3];
    logic signed [63:0]      qb_next [3];
    logic signed [32:0]      vs_reg [3];
    logic signed [32:0]      vs_next [3];
    logic [2:0]              an1_reg;
    logic [2:0]              an1_next;
    logic [2:0][31:0]        ab1_reg;
    logic [2:0][31:0]        ab1_next;

    // stage 2
    logic                    v2_reg;
    op_t                     op2_reg;
    logic signed [65:0]      dot2_reg;
    logic signed [65:0]      dot2_next;
    logic signed [65:0]      cr2_reg [3];
    logic signed [65:0]      cr2_next [3];
    logic [63:0]             ssa2_reg;
    logic [63:0]             ssa2_next;
    logic [63:0]             ssb2_reg;
    logic [63:0]             ssb2_next;
    sat_t                    vr2_reg [3];
    sat_t                    vr2_next [3];
    logic [2:0]              an2_reg;
    logic [2:0][31:0]        ab2_reg;

    // stage 3
    logic                    v3_reg;
    front_t                  f3_reg;
    front_t                  f3_next;
    sat_t                    dq;
    sat_t                    cq [3];
    logic signed [65:0]      dneg;

    always_comb begin
        av[0] = in_item.ax;
        av[1] = in_item.ay;
        av[2] = in_item.az;
        bv[0] = in_item.bx;
        bv[1] = in_item.by_comp;
        bv[2] = in_item.bz;
        sub_sel = (in_item.op == OP_SUB) || (in_item.op == OP_SUBS);
        scl_sel = (in_item.op == OP_ADDS) || (in_item.op == OP_SUBS);
        opnd = '0;
        for (int i = 0; i < 3; i++) begin
            pd_next[i] = av[i] * bv[i];
            qa_next[i] = av[i] * av[i];
            qb_next[i] = bv[i] * bv[i];
            opnd = scl_sel ? in_item.scalar_in : bv[i];
            vs_next[i] = sub_sel ? (33'(av[i]) - 33'(opnd)) : (33'(av[i]) + 33'(opnd));
            an1_next[i] = av[i][31];
            ab1_next[i] = av[i][31] ? (32'd0 - av[i]) : av[i];
        end
        pc_next[0] = av[1] * bv[2];
        pc_next[1] = bv[1] * av[2];
        pc_next[2] = bv[0] * av[2];
        pc_next[3] = av[0] * bv[2];
        pc_next[4] = av[0] * bv[1];
        pc_next[5] = bv[0] * av[1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg <= in_item.op;
            pd_reg  <= pd_next;
            pc_reg  <= pc_next;
            qa_reg  <= qa_next;
            qb_reg  <= qb_next;
            vs_reg  <= vs_next;
            an1_reg <= an1_next;
            ab1_reg <= ab1_next;
        end
    end

    always_comb begin
        dot2_next = 66'(pd_reg[0]) + 66'(pd_reg[1]) + 66'(pd_reg[2]);
        for (int i = 0; i < 3; i++) begin
            cr2_next[i] = 66'(pc_reg[2*i]) - 66'(pc_reg[2*i+1]);
            vr2_next[i] = sat_q(50'(vs_reg[i]));
        end
        ssa2_next = $unsigned(qa_reg[0]) + $unsigned(qa_reg[1]) + $unsigned(qa_reg[2]);
        ssb2_next = $unsigned(qb_reg[0]) + $unsigned(qb_reg[1]) + $unsigned(qb_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg  <= op1_reg;
            dot2_reg <= dot2_next;
            cr2_reg  <= cr2_next;
            ssa2_reg <= ssa2_next;
            ssb2_reg <= ssb2_next;
            vr2_reg  <= vr2_next;
            an2_reg  <= an1_reg;
            ab2_reg  <= ab1_reg;
        end
    end

    // floor to Q16.16 is an arithmetic shift of the Q34.32 sum
    always_comb begin
        dq   = sat_q(dot2_reg[65:16]);
        dneg = -dot2_reg;
        for (int i = 0; i < 3; i++) begin
            cq[i] = sat_q(cr2_reg[i][65:16]);
        end
        f3_next             = '0;
        f3_next.mid.op      = op2_reg;
        f3_next.mid.dot_neg = dot2_reg[65];
        f3_next.mid.dot_mag = dot2_reg[65] ? dneg[63:0] : dot2_reg[63:0];
        f3_next.mid.a_neg   = an2_reg;
        f3_next.mid.a_abs   = ab2_reg;
        f3_next.ssq_a       = ssa2_reg;
        f3_next.ssq_b       = ssb2_reg;
        f3_next.mid.early.status = ST_OK;
        case (op2_reg)
            OP_ADD, OP_SUB, OP_ADDS, OP_SUBS: begin
                f3_next.mid.early.rx = vr2_reg[0].val;
                f3_next.mid.early.ry = vr2_reg[1].val;
                f3_next.mid.early.rz = vr2_reg[2].val;
                f3_next.mid.early.status =
                    (vr2_reg[0].sat || vr2_reg[1].sat || vr2_reg[2].sat) ? ST_SAT : ST_OK;
            end
            OP_DOT: begin
                f3_next.mid.early.sc     = dq.val;
                f3_next.mid.early.status = dq.sat ? ST_SAT : ST_OK;
            end
            OP_CROSS: begin
                f3_next.mid.early.rx = cq[0].val;
                f3_next.mid.early.ry = cq[1].val;
                f3_next.mid.early.rz = cq[2].val;
                f3_next.mid.early.status =
                    (cq[0].sat || cq[1].sat || cq[2].sat) ? ST_SAT : ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_reg <= f3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = f3_reg;

endmodule

FILE: hw/rtl/v3a_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
// Depends on v3a_pkg.
module v3a_isqrt #(
    parameter int RootW = v3a_pkg::ROOT_W
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [2*RootW-1:0] n,
    output logic [RootW-1:0]   root
);
    import v3a_pkg::*;

    localparam int NW = 2 * RootW;

    logic [NW-1:0]    rem_reg  [RootW-1];
    logic [RootW-1:0] root_reg [RootW];

    for (genvar k = 0; k < RootW; k++) begin : g_stage
        localparam int B = RootW - 1 - k;
        logic [NW-1:0]    rem_in;
        logic [NW-1:0]    trial;
        logic [RootW-1:0] root_in;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in  = n;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
        assign trial = (NW'(root_in) << (B + 1)) | (NW'(1) << (2 * B));
        assign take  = rem_in >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= take ? (root_in | (RootW'(1) << B)) : root_in;
            end
        end

        if (k < RootW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign root = root_reg[RootW-1];

endmodule

FILE: hw/rtl/v3a_divq.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage; needs num < den * 2^QuoW.
// Depends on v3a_pkg.
module v3a_divq #(
    parameter int DenW = v3a_pkg::COSD_W,
    parameter int QuoW = v3a_pkg::QUO_W
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [DenW+QuoW-1:0] num,
    input  logic [DenW-1:0]      den,
    output logic [QuoW-1:0]      quo
);
    import v3a_pkg::*;

    localparam int W = DenW + QuoW;

    logic [W-1:0]    rem_reg [QuoW-1];
    logic [DenW-1:0] den_reg [QuoW-1];
    logic [QuoW-1:0] quo_reg [QuoW];

    for (genvar k = 0; k < QuoW; k++) begin : g_stage
        localparam int B = QuoW - 1 - k;
        logic [W-1:0]    rem_in;
        logic [W-1:0]    shifted;
        logic [DenW-1:0] den_in;
        logic [QuoW-1:0] quo_in;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = W'(den_in) << B;
        assign ge      = rem_in >= shifted;

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= {quo_in[QuoW-2:0], ge};
            end
        end

        if (k < QuoW - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? (rem_in - shifted) : rem_in;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QuoW-1];

endmodule

FILE: hw/rtl/v3a_delay.sv
`timescale 1ns / 1ps
// Sideband delay line with valid bits, matched to the root and divide pipelines.
// Depends on v3a_pkg.
module v3a_delay #(
    parameter int Width = 1,
    parameter int Depth = v3a_pkg::ROOT_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [Width-1:0] in_data,
    output logic             out_valid,
    output logic [Width-1:0] out_data
);
    import v3a_pkg::*;

    logic             vld_reg [Depth];
    logic [Width-1:0] dat_reg [Depth];

    for (genvar k = 0; k < Depth; k++) begin : g_tap
        logic             v_in;
        logic [Width-1:0] d_in;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign d_in = in_data;
        end else begin : g_next
            assign v_in = vld_reg[k-1];
            assign d_in = dat_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dat_reg[k] <= d_in;
            end
        end
    end

    assign out_valid = vld_reg[Depth-1];
    assign out_data  = dat_reg[Depth-1];

endmodule

FILE: hw/rtl/vector3_alu.sv
`timescale 1ns / 1ps
// Q16.16 three-component vector ALU, fully pipelined.
// Stages from input accept to m_tvalid: 3 front, 32 root, 1 multiply, 32 divide,
// 1 output register. Throughput: one item per cycle while the pipe is not held.
// The whole pipe advances together; it holds while a result waits at the output.
// aresetn (synchronous, active low) clears all valid bits. Uses v3a_pkg and submodules.
module vector3_alu (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,   // ax, ay, az, bx, by_comp, bz, scalar_in
    input  logic [3:0]   s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // rx, ry, rz, scalar_out
    output logic [1:0]   m_tuser    // status
);
    import v3a_pkg::*;

    logic         en;
    item_t        in_item;
    logic         f_valid;
    front_t       f_data;
    logic [31:0]  ma_root;
    logic [31:0]  mb_root;
    logic         mid_valid;
    mid_t         mid_dly;

    logic         m1_valid_reg;
    mid_t         m1_mid_reg;
    logic [31:0]  ma_reg;
    logic         zb_reg;
    logic [63:0]  prod_reg;

    tail_t        tail_in;
    logic         tail_valid;
    tail_t        tail_out;
    logic [31:0]  cos_q;
    logic [31:0]  nrm_q [3];

    res_t         r;
    sat_t         c_cos;
    sat_t         c_mag;
    sat_t         c_n [3];

    logic         m_tvalid_reg;
    res_t         m_res_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign in_item.op        = op_t'(s_tuser);
    assign in_item.ax        = s_tdata[31:0];
    assign in_item.ay        = s_tdata[63:32];
    assign in_item.az        = s_tdata[95:64];
    assign in_item.bx        = s_tdata[127:96];
    assign in_item.by_comp   = s_tdata[159:128];
    assign in_item.bz        = s_tdata[191:160];
    assign in_item.scalar_in = s_tdata[223:192];

    v3a_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .out_valid(f_valid),
        .out_data (f_data)
    );

    v3a_isqrt #(.RootW(ROOT_W)) u_sqrt_a (
        .aclk(aclk),
        .en  (en),
        .n   (f_data.ssq_a),
        .root(ma_root)
    );

    v3a_isqrt #(.RootW(ROOT_W)) u_sqrt_b (
        .aclk(aclk),
        .en  (en),
        .n   (f_data.ssq_b),
        .root(mb_root)
    );

    v3a_delay #(.Width($bits(mid_t)), .Depth(ROOT_W)) u_dly_mid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (f_valid),
        .in_data  (f_data.mid),
        .out_valid(mid_valid),
        .out_data (mid_dly)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= mid_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_mid_reg <= mid_dly;
            ma_reg     <= ma_root;
            zb_reg     <= (mb_root == '0);
            prod_reg   <= ma_root * mb_root;
        end
    end

    // cosine quotient needs 32 bits or less: dot_mag < |a||b| * 2^16
    always_comb begin
        tail_in         = '0;
        tail_in.op      = m1_mid_reg.op;
        tail_in.early   = m1_mid_reg.early;
        tail_in.dot_neg = m1_mid_reg.dot_neg;
        tail_in.a_neg   = m1_mid_reg.a_neg;
        tail_in.ma      = ma_reg;
        tail_in.zero_a  = (ma_reg == '0);
        tail_in.zero_b  = zb_reg;
        tail_in.big     = {16'd0, m1_mid_reg.dot_mag} >= {prod_reg, 16'd0};
    end

    v3a_divq #(.DenW(COSD_W), .QuoW(QUO_W)) u_div_cos (
        .aclk(aclk),
        .en  (en),
        .num ({16'd0, m1_mid_reg.dot_mag, 16'd0}),
        .den (prod_reg),
        .quo (cos_q)
    );

    for (genvar i = 0; i < 3; i++) begin : g_norm
        v3a_divq #(.DenW(NRMD_W), .QuoW(QUO_W)) u_div_nrm (
            .aclk(aclk),
            .en  (en),
            .num ({16'd0, m1_mid_reg.a_abs[i], 16'd0}),
            .den (ma_reg),
            .quo (nrm_q[i])
        );
    end

    v3a_delay #(.Width($bits(tail_t)), .Depth(QUO_W)) u_dly_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (m1_valid_reg),
        .in_data  (tail_in),
        .out_valid(tail_valid),
        .out_data (tail_out)
    );

    always_comb begin
        c_cos = sign_sat(tail_out.dot_neg, cos_q);
        c_mag = sign_sat(1'b0, tail_out.ma);
        for (int i = 0; i < 3; i++) begin
            c_n[i] = sign_sat(tail_out.a_neg[i], nrm_q[i]);
        end
        r = tail_out.early;
        case (tail_out.op)
            OP_COS: begin
                r = '0;
                if (tail_out.zero_a || tail_out.zero_b) begin
                    r.status = ST_ZERO;
                end else if (tail_out.big) begin
                    r.sc     = tail_out.dot_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    r.status = ST_SAT;
                end else begin
                    r.sc     = c_cos.val;
                    r.status = c_cos.sat ? ST_SAT : ST_OK;
                end
            end
            OP_NORM: begin
                r = '0;
                if (tail_out.zero_a) begin
                    r.status = ST_ZERO;
                end else begin
                    r.rx     = c_n[0].val;
                    r.ry     = c_n[1].val;
                    r.rz     = c_n[2].val;
                    r.status = (c_n[0].sat || c_n[1].sat || c_n[2].sat) ? ST_SAT : ST_OK;
                end
            end
            OP_MAG: begin
                r        = '0;
                r.sc     = c_mag.val;
                r.status = c_mag.sat ? ST_SAT : ST_OK;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= tail_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_res_reg <= r;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_res_reg.sc, m_res_reg.rz, m_res_reg.ry, m_res_reg.rx};
    assign m_tuser  = m_res_reg.status;

    a_zero_len_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_ZERO) |-> (m_tdata == '0))
        else $error("zero-length item with nonzero payload");

    a_root_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m1_valid_reg && ma_reg == '0) |-> (m1_mid_reg.a_abs == '0))
        else $error("zero root for a nonzero vector");

    a_dot_needs_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (m1_valid_reg && m1_mid_reg.dot_mag != '0) |-> (ma_reg != '0))
        else $error("nonzero dot with zero magnitude of a");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
